FILE: rtl/core/drive_power_state_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// Drive power state sequencer assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef DRIVE_POWER_STATE_SEQUENCER_UNIT_DEFINES_SVH
`define DRIVE_POWER_STATE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication
`define DPSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DPSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dpss_pkg.sv
// ----------------------------------------------------------------------------
// Drive power state sequencer package
// Types, state codes, command codes and control words shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpss_pkg;

  localparam int unsigned RegW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned StateW = 3;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  // Sequencer states
  localparam logic [StateW-1:0] ST_OFF        = 3'd0;
  localparam logic [StateW-1:0] ST_SAFE_RESET = 3'd1;
  localparam logic [StateW-1:0] ST_PREPARE    = 3'd2;
  localparam logic [StateW-1:0] ST_SWITCH_ON  = 3'd3;
  localparam logic [StateW-1:0] ST_ON         = 3'd4;
  localparam logic [StateW-1:0] ST_HOMED      = 3'd5;

  // Commands
  localparam logic [CmdW-1:0] CMD_NONE    = 2'd0;
  localparam logic [CmdW-1:0] CMD_ENABLE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_DISABLE = 2'd2;
  localparam logic [CmdW-1:0] CMD_HOME    = 2'd3;

  // Request kinds carried on tuser
  localparam logic ACT_STATUS = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // Standard control words
  localparam logic [RegW-1:0] CW_FAULT_RESET     = 16'h0080;
  localparam logic [RegW-1:0] CW_SHUTDOWN        = 16'h0006;
  localparam logic [RegW-1:0] CW_SWITCH_ON       = 16'h0007;
  localparam logic [RegW-1:0] CW_ENABLE_OP       = 16'h000F;
  localparam logic [RegW-1:0] CW_DISABLE_VOLTAGE = 16'h0000;

  // Register indexes
  localparam logic [AddrW-1:0] REG_RESET_DELAY  = 3'd0;
  localparam logic [AddrW-1:0] REG_INIT_TIMEOUT = 3'd1;
  localparam logic [AddrW-1:0] REG_READY_MASK   = 3'd2;
  localparam logic [AddrW-1:0] REG_ON_MASK      = 3'd3;
  localparam logic [AddrW-1:0] REG_OFF_MASK     = 3'd4;
  localparam logic [AddrW-1:0] REG_HOMING_MASK  = 3'd5;
  localparam logic [AddrW-1:0] REG_HOME_MOVE    = 3'd6;

  // Register reset values
  localparam logic [RegW-1:0] RST_RESET_DELAY  = 16'd500;
  localparam logic [RegW-1:0] RST_INIT_TIMEOUT = 16'd5000;
  localparam logic [RegW-1:0] RST_READY_MASK   = 16'd33;
  localparam logic [RegW-1:0] RST_ON_MASK      = 16'd39;
  localparam logic [RegW-1:0] RST_OFF_MASK     = 16'd64;
  localparam logic [RegW-1:0] RST_HOMING_MASK  = 16'd5120;
  localparam logic [RegW-1:0] RST_HOME_MOVE    = 16'd31;

  typedef struct packed {
    logic [RegW-1:0] reset_delay_ms;
    logic [RegW-1:0] init_timeout_ms;
    logic [RegW-1:0] ready_mask;
    logic [RegW-1:0] on_mask;
    logic [RegW-1:0] off_mask;
    logic [RegW-1:0] homing_mask;
    logic [RegW-1:0] home_move_word;
  } cfg_t;

  typedef struct packed {
    logic             action;
    logic [CmdW-1:0]  new_command;
    logic [RegW-1:0]  status_in;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [StateW-1:0] seq_state;
    logic [CmdW-1:0]   command;
    logic [TimeW-1:0]  start_time;
    logic [RegW-1:0]   control_word;
  } seq_t;

  // Packed so that control_word sits in the lowest bits
  typedef struct packed {
    logic              timed_out;
    logic [CmdW-1:0]   pending_command;
    logic [StateW-1:0] drive_state;
    logic [RegW-1:0]   control_word;
  } result_t;

endpackage

FILE: rtl/core/dpss_cfg_regs.sv
// ----------------------------------------------------------------------------
// Drive power state sequencer configuration registers
// Seven 16-bit write-only registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpss_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [dpss_pkg::AddrW-1:0] cfg_addr_i,
  input  logic [dpss_pkg::RegW-1:0]  cfg_wdata_i,
  output dpss_pkg::cfg_t            cfg_o
);
  import dpss_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Address decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_RESET_DELAY:  cfg_d.reset_delay_ms  = cfg_wdata_i;
        REG_INIT_TIMEOUT: cfg_d.init_timeout_ms = cfg_wdata_i;
        REG_READY_MASK:   cfg_d.ready_mask      = cfg_wdata_i;
        REG_ON_MASK:      cfg_d.on_mask         = cfg_wdata_i;
        REG_OFF_MASK:     cfg_d.off_mask        = cfg_wdata_i;
        REG_HOMING_MASK:  cfg_d.homing_mask     = cfg_wdata_i;
        REG_HOME_MOVE:    cfg_d.home_move_word  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_delay_ms  <= RST_RESET_DELAY;
      cfg_q.init_timeout_ms <= RST_INIT_TIMEOUT;
      cfg_q.ready_mask      <= RST_READY_MASK;
      cfg_q.on_mask         <= RST_ON_MASK;
      cfg_q.off_mask        <= RST_OFF_MASK;
      cfg_q.homing_mask     <= RST_HOMING_MASK;
      cfg_q.home_move_word  <= RST_HOME_MOVE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/dpss_step.sv
// ----------------------------------------------------------------------------
// Drive power state sequencer step logic
// Combinational next-state and result for one request against current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpss_step (
  input  dpss_pkg::item_t   item_i,
  input  dpss_pkg::seq_t    cur_i,
  input  dpss_pkg::cfg_t    cfg_i,
  output dpss_pkg::seq_t    nxt_o,
  output dpss_pkg::result_t res_o
);
  import dpss_pkg::*;

  logic [TimeW-1:0] elapsed;
  logic             delay_done;
  logic             init_expired;
  logic             tout;
  seq_t             nxt;

  // Wrapping time since the sequence started
  assign elapsed      = item_i.now_ms - cur_i.start_time;
  assign delay_done   = elapsed > {{(TimeW-RegW){1'b0}}, cfg_i.reset_delay_ms};
  assign init_expired = elapsed > {{(TimeW-RegW){1'b0}}, cfg_i.init_timeout_ms};

  always_comb begin
    nxt  = cur_i;
    tout = 1'b0;
    if (item_i.action == ACT_LOAD) begin
      nxt.command = item_i.new_command;
    end else begin
      case (cur_i.command)
        CMD_ENABLE: begin
          case (cur_i.seq_state)
            ST_OFF: begin
              nxt.start_time   = item_i.now_ms;
              nxt.control_word = CW_FAULT_RESET;
              nxt.seq_state    = ST_SAFE_RESET;
            end
            ST_SAFE_RESET: begin
              nxt.control_word = CW_SHUTDOWN;
              if (delay_done) nxt.seq_state = ST_PREPARE;
            end
            ST_PREPARE: begin
              nxt.control_word = CW_SWITCH_ON;
              if ((item_i.status_in & cfg_i.ready_mask) == cfg_i.ready_mask)
                nxt.seq_state = ST_SWITCH_ON;
            end
            ST_SWITCH_ON: begin
              nxt.control_word = CW_ENABLE_OP;
              if ((item_i.status_in & cfg_i.on_mask) == cfg_i.on_mask)
                nxt.seq_state = ST_ON;
            end
            default: nxt.command = CMD_NONE;
          endcase
          // Restart from off when on is not reached in time; a step that starts
          // from off is excluded from the check and never expires
          if (nxt.seq_state != ST_ON && nxt.seq_state != ST_OFF &&
              cur_i.seq_state != ST_OFF && init_expired) begin
            nxt.seq_state = ST_OFF;
            tout          = 1'b1;
          end
        end
        CMD_DISABLE: begin
          nxt.control_word = CW_DISABLE_VOLTAGE;
          if ((item_i.status_in & cfg_i.off_mask) == cfg_i.off_mask) begin
            nxt.seq_state = ST_OFF;
            nxt.command   = CMD_NONE;
          end
        end
        CMD_HOME: begin
          if (cur_i.seq_state == ST_ON) begin
            nxt.control_word = cfg_i.home_move_word;
            if ((item_i.status_in & cfg_i.homing_mask) == cfg_i.homing_mask)
              nxt.seq_state = ST_HOMED;
          end else if (cur_i.seq_state == ST_HOMED) begin
            nxt.control_word = CW_ENABLE_OP;
            nxt.command      = CMD_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  assign nxt_o                 = nxt;
  assign res_o.timed_out       = tout;
  assign res_o.pending_command = nxt.command;
  assign res_o.drive_state     = nxt.seq_state;
  assign res_o.control_word    = nxt.control_word;

endmodule

FILE: rtl/core/drive_power_state_sequencer_unit.sv
// Drive power state sequencer: steps a servo drive through a CiA402-style
// power-up, power-down and homing sequence, one request at a time. A request
// is either a command load (tuser high) or a status update (tuser low); each
// request yields exactly one result. The result shows on the master side
// after passing the input register, then the step logic into the result
// register; a stall on the result side holds the request in the input register.
// One request is taken every cycle while the result side keeps up; the rate
// is set by the combinational step logic, whose state registers feed straight
// back into the next request.
// ----------------------------------------------------------------------------
// Drive power state sequencer top level
// Input register, step logic with state registers, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drive_power_state_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [dpss_pkg::AddrW-1:0]    cfg_addr_i,
  input  logic [dpss_pkg::RegW-1:0]     cfg_wdata_i,
  // Request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // new_command[1:0], status_in[17:2], now_ms[49:18], zero [55:50]
  input  logic [dpss_pkg::InDataW-1:0]  s_axis_tdata,
  // action[0]
  input  logic                          s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // control_word[15:0], drive_state[18:16], pending_command[20:19],
  // timed_out[21], zero [23:22]
  output logic [dpss_pkg::OutDataW-1:0] m_axis_tdata
);
  import dpss_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  seq_t    seq_q, seq_nxt;
  result_t res_q, res_nxt;
  logic    out_vld_q;
  logic    advance;
  logic    in_take;

  dpss_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: step when the result register is free or being drained
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action      <= s_axis_tuser;
      item_q.new_command <= s_axis_tdata[1:0];
      item_q.status_in   <= s_axis_tdata[17:2];
      item_q.now_ms      <= s_axis_tdata[49:18];
    end
  end

  dpss_step u_step (
    .item_i (item_q),
    .cur_i  (seq_q),
    .cfg_i  (cfg),
    .nxt_o  (seq_nxt),
    .res_o  (res_nxt)
  );

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q.seq_state    <= ST_OFF;
      seq_q.command      <= CMD_NONE;
      seq_q.start_time   <= '0;
      seq_q.control_word <= CW_DISABLE_VOLTAGE;
    end else if (advance) begin
      seq_q <= seq_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_nxt;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-$bits(result_t)){1'b0}}, res_q};

endmodule

FILE: rtl/core/dpss_checker.sv
// ----------------------------------------------------------------------------
// Drive power state sequencer port checker
// Watches the result stream for stall holding and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "drive_power_state_sequencer_unit_defines.svh"

module dpss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dpss_pkg::OutDataW-1:0] m_axis_tdata
);
  import dpss_pkg::*;

  logic              out_stall;
  logic              res_tout;
  logic [StateW-1:0] res_state;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign res_tout  = m_axis_tdata[21];
  assign res_state = m_axis_tdata[18:16];

  // Stalled result keeps its value
  `DPSS_ASSERT_NXT(a_res_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result moved")

  // A timeout restart always lands in off
  `DPSS_ASSERT_IMP(a_tout_state, m_axis_tvalid && res_tout, res_state == ST_OFF, "bad timeout")

  // Reported state stays within the defined states
  `DPSS_ASSERT_IMP(a_state_range, m_axis_tvalid, res_state <= ST_HOMED, "state out of range")

  // Request side is always free when nothing is held on the result side
  `DPSS_ASSERT_NXT(a_drain_ready, !m_axis_tvalid && !s_axis_tvalid, s_axis_tready, "blocked idle")

endmodule

bind drive_power_state_sequencer_unit dpss_checker u_dpss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
